FILE: hw/rtl/srma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srma_pkg
// Shared types, field widths and codes for the shift register
// multiplicity analyzer.
// ----------------------------------------------------------------------------
package srma_pkg;

    // item field widths
    localparam int REQ_W       = 2;
    localparam int BIN_IDX_W   = 9;
    localparam int OCC_OUT_W   = 9;
    localparam int BIN_COUNT_W = 32;

    // configuration register widths
    localparam int GATE_LEN_W   = 9;
    localparam int PREDELAY_W   = 7;
    localparam int LONG_DELAY_W = 13;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] CFG_IDX_GATE_LENGTH = 2'd0;
    localparam logic [1:0] CFG_IDX_PREDELAY    = 2'd1;
    localparam logic [1:0] CFG_IDX_LONG_DELAY  = 2'd2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ_RA = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ_A  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;

    // control group for a line of shift cells
    typedef struct packed {
        logic shift;
        logic clear;
    } line_ctrl_t;

endpackage

FILE: hw/rtl/srma_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srma_if
// Valid/ready channels for requests and results of the analyzer.
// ----------------------------------------------------------------------------
interface srma_req_if import srma_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic                 pulse;
    logic [BIN_IDX_W-1:0] bin_index;

    modport source (output valid, output req_type, output pulse, output bin_index,
                    input ready);
    modport sink (input valid, input req_type, input pulse, input bin_index,
                  output ready);
endinterface

interface srma_rsp_if import srma_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OCC_OUT_W-1:0]   occupancy;
    logic                   ra_sampled;
    logic                   a_sampled;
    logic [BIN_COUNT_W-1:0] bin_count;

    modport source (output valid, output occupancy, output ra_sampled,
                    output a_sampled, output bin_count, input ready);
    modport sink (input valid, input occupancy, input ra_sampled,
                  input a_sampled, input bin_count, output ready);
endinterface

FILE: hw/rtl/shift_register_multiplicity_analyzer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_register_multiplicity_analyzer_unit
// Shift register coincidence analyzer with RA and A multiplicity histograms.
//
// Requests come in on req: a tick (one detector clock, with its pulse bit)
// or a read of one RA or A histogram bin. Every request gives one result on
// rsp: the gate occupancy after the step, the two sample flags and, for
// reads, the bin count. The gate window and the predelay line are rows of
// shift cells; the long delay line and both histograms live in RAM.
// A result passes through the stage 1 register and the output register.
// One request is taken every cycle while rsp does not stall and no clear
// runs; the histogram read-modify-write keeps this rate, forwarding the
// write of the previous tick to the next read of the same bin.
// After reset the histograms are cleared one bin per cycle, all MAX_GATE+1
// bins, while req.ready is low; APB writes are taken throughout.
// When rsp is stalled the result waits in the output register and one more
// request is still taken into the stage ahead of it before req.ready drops.
// Configuration must be written over APB only while no request is in flight;
// the block does not enforce it. Writing gate_length empties the gate window.
// ----------------------------------------------------------------------------
module shift_register_multiplicity_analyzer_unit import srma_pkg::*; #(
    parameter int MAX_GATE       = 256,
    parameter int MAX_PREDELAY   = 64,
    parameter int MAX_LONG_DELAY = 4096,
    parameter int COUNT_WIDTH    = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    srma_req_if.sink              req,
    srma_rsp_if.source            rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int OCC_W = $clog2(MAX_GATE + 1);
    localparam int PD_W  = $clog2(MAX_PREDELAY + 1);
    localparam int LD_W  = $clog2(MAX_LONG_DELAY + 1);
    localparam int LA_W  = $clog2(MAX_LONG_DELAY);
    localparam int LS_W  = $clog2(2 * MAX_LONG_DELAY);
    localparam int HIST_DEPTH = MAX_GATE + 1;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // configuration registers
    logic [GATE_LEN_W-1:0]   gate_length_reg;
    logic [PREDELAY_W-1:0]   predelay_reg;
    logic [LONG_DELAY_W-1:0] long_delay_reg;
    logic                    cfg_wr;
    logic                    gate_cfg_wr;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign gate_cfg_wr = cfg_wr && (paddr[3:2] == CFG_IDX_GATE_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_length_reg <= GATE_LEN_W'(64);
            predelay_reg    <= PREDELAY_W'(4);
            long_delay_reg  <= LONG_DELAY_W'(1024);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                CFG_IDX_GATE_LENGTH: gate_length_reg <= pwdata[GATE_LEN_W-1:0];
                CFG_IDX_PREDELAY:    predelay_reg    <= pwdata[PREDELAY_W-1:0];
                CFG_IDX_LONG_DELAY:  long_delay_reg  <= pwdata[LONG_DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            CFG_IDX_GATE_LENGTH: prdata = APB_DATA_W'(gate_length_reg);
            CFG_IDX_PREDELAY:    prdata = APB_DATA_W'(predelay_reg);
            CFG_IDX_LONG_DELAY:  prdata = APB_DATA_W'(long_delay_reg);
            default:             prdata = '0;
        endcase
    end

    // lengths clamped to 1..line depth
    logic [OCC_W-1:0] gl;
    logic [PD_W-1:0]  pd;
    logic [LD_W-1:0]  ld;

    always_comb
    begin
        if (gate_length_reg == '0)
        begin
            gl = OCC_W'(1);
        end
        else if (32'(gate_length_reg) > 32'(MAX_GATE))
        begin
            gl = OCC_W'(MAX_GATE);
        end
        else
        begin
            gl = OCC_W'(gate_length_reg);
        end

        if (predelay_reg == '0)
        begin
            pd = PD_W'(1);
        end
        else if (32'(predelay_reg) > 32'(MAX_PREDELAY))
        begin
            pd = PD_W'(MAX_PREDELAY);
        end
        else
        begin
            pd = PD_W'(predelay_reg);
        end

        if (long_delay_reg == '0)
        begin
            ld = LD_W'(1);
        end
        else if (32'(long_delay_reg) > 32'(MAX_LONG_DELAY))
        begin
            ld = LD_W'(MAX_LONG_DELAY);
        end
        else
        begin
            ld = LD_W'(long_delay_reg);
        end
    end

    // handshake and pipeline control
    logic s1_valid_reg;
    logic out_valid_reg;
    logic clr_active_reg;
    logic out_free;
    logic advance;
    logic accept;
    logic accept_tick;
    logic s1_move;

    assign out_free    = !out_valid_reg || rsp.ready;
    assign advance     = !s1_valid_reg || out_free;
    assign req.ready   = advance && !clr_active_reg;
    assign accept      = req.valid && req.ready;
    assign accept_tick = accept && (req.req_type == REQ_TICK);
    assign s1_move     = s1_valid_reg && out_free;

    // gate window and predelay line
    line_ctrl_t gate_ctrl;
    line_ctrl_t pre_ctrl;
    logic       leaving;
    logic       entering;

    assign gate_ctrl.shift = accept_tick;
    assign gate_ctrl.clear = gate_cfg_wr;
    assign pre_ctrl.shift  = accept_tick;
    assign pre_ctrl.clear  = 1'b0;

    srma_delay_line #(
        .DEPTH (MAX_GATE)
    ) u_gate (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (gate_ctrl),
        .din     (entering),
        .tap_len (gl),
        .tap_bit (leaving)
    );

    srma_delay_line #(
        .DEPTH (MAX_PREDELAY)
    ) u_predelay (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (pre_ctrl),
        .din     (req.pulse),
        .tap_len (pd),
        .tap_bit (entering)
    );

    // occupancy
    logic [OCC_W-1:0] window_count_reg;
    logic [OCC_W-1:0] occ_left;
    logic [OCC_W-1:0] occ_tick;

    always_comb
    begin
        occ_left = window_count_reg;
        if (leaving && (window_count_reg != '0))
        begin
            occ_left = window_count_reg - OCC_W'(1);
        end
        occ_tick = entering ? occ_left + OCC_W'(1) : occ_left;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_count_reg <= '0;
        end
        else if (gate_cfg_wr)
        begin
            window_count_reg <= '0;
        end
        else if (accept_tick)
        begin
            window_count_reg <= occ_tick;
        end
    end

    // long delay line: ring in RAM, fill count stands in for the reset value
    logic [LA_W-1:0] long_pos_reg;
    logic [LA_W-1:0] long_pos_next;
    logic [LD_W-1:0] long_fill_reg;
    logic [LS_W-1:0] long_sum;
    logic [LA_W-1:0] long_raddr;
    logic            long_rdata;
    logic            long_hit;

    assign long_pos_next = (long_pos_reg == LA_W'(MAX_LONG_DELAY - 1)) ?
                           '0 : long_pos_reg + LA_W'(1);
    assign long_sum      = LS_W'(long_pos_next) + LS_W'(MAX_LONG_DELAY) - LS_W'(ld);
    assign long_raddr    = (long_sum >= LS_W'(MAX_LONG_DELAY)) ?
                           LA_W'(long_sum - LS_W'(MAX_LONG_DELAY)) : LA_W'(long_sum);
    assign long_hit      = (long_fill_reg >= ld);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_pos_reg  <= '0;
            long_fill_reg <= '0;
        end
        else if (accept_tick)
        begin
            long_pos_reg <= long_pos_next;
            if (long_fill_reg != LD_W'(MAX_LONG_DELAY))
            begin
                long_fill_reg <= long_fill_reg + LD_W'(1);
            end
        end
    end

    srma_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LONG_DELAY)
    ) u_long_line (
        .clk   (clk),
        .we    (accept_tick),
        .waddr (long_pos_next),
        .wdata (req.pulse),
        .re    (accept_tick),
        .raddr (long_raddr),
        .rdata (long_rdata)
    );

    // histogram clearing pass after reset
    logic [OCC_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + OCC_W'(1);
            if (clr_addr_reg == OCC_W'(MAX_GATE))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // histogram address for this request
    logic             bin_in_range;
    logic [OCC_W-1:0] hist_raddr;

    assign bin_in_range = (32'(req.bin_index) <= 32'(MAX_GATE));

    always_comb
    begin
        if (req.req_type == REQ_TICK)
        begin
            hist_raddr = occ_tick;
        end
        else if (bin_in_range)
        begin
            hist_raddr = OCC_W'(req.bin_index);
        end
        else
        begin
            hist_raddr = '0;
        end
    end

    // stage 1
    logic [REQ_W-1:0]       s1_req_reg;
    logic                   s1_pulse_reg;
    logic                   s1_in_range_reg;
    logic                   s1_long_hit_reg;
    logic [OCC_W-1:0]       s1_occ_reg;
    logic [OCC_W-1:0]       s1_addr_reg;
    logic                   bypass_hit_reg;
    logic [COUNT_WIDTH-1:0] ra_byp_reg;
    logic [COUNT_WIDTH-1:0] a_byp_reg;

    logic [COUNT_WIDTH-1:0] ra_rdata;
    logic [COUNT_WIDTH-1:0] a_rdata;
    logic [COUNT_WIDTH-1:0] ra_cur;
    logic [COUNT_WIDTH-1:0] a_cur;
    logic [COUNT_WIDTH-1:0] ra_new;
    logic [COUNT_WIDTH-1:0] a_new;
    logic                   s1_tick;
    logic                   ra_samp;
    logic                   a_samp;
    logic [BIN_COUNT_W-1:0] s1_count;
    logic                   bypass_next;

    assign s1_tick = (s1_req_reg == REQ_TICK);
    assign ra_cur  = bypass_hit_reg ? ra_byp_reg : ra_rdata;
    assign a_cur   = bypass_hit_reg ? a_byp_reg : a_rdata;
    assign ra_samp = s1_tick && s1_pulse_reg;
    assign a_samp  = s1_tick && s1_long_hit_reg && long_rdata;
    assign ra_new  = (ra_samp && (ra_cur != COUNT_MAX)) ? ra_cur + COUNT_WIDTH'(1) : ra_cur;
    assign a_new   = (a_samp && (a_cur != COUNT_MAX)) ? a_cur + COUNT_WIDTH'(1) : a_cur;

    // a tick writing back now hides the RAM word from the request behind it
    assign bypass_next = accept && s1_move && s1_tick && (s1_addr_reg == hist_raddr);

    always_comb
    begin
        s1_count = '0;
        if (s1_in_range_reg && (s1_req_reg == REQ_READ_RA))
        begin
            s1_count = BIN_COUNT_W'(ra_cur);
        end
        else if (s1_in_range_reg && (s1_req_reg == REQ_READ_A))
        begin
            s1_count = BIN_COUNT_W'(a_cur);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            bypass_hit_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg   <= accept;
            bypass_hit_reg <= bypass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg      <= req.req_type;
            s1_pulse_reg    <= req.pulse;
            s1_in_range_reg <= bin_in_range;
            s1_long_hit_reg <= long_hit;
            s1_occ_reg      <= (req.req_type == REQ_TICK) ? occ_tick : window_count_reg;
            s1_addr_reg     <= hist_raddr;
            ra_byp_reg      <= ra_new;
            a_byp_reg       <= a_new;
        end
    end

    // histogram RAMs, shared write port with the clearing pass
    logic             ra_we;
    logic             a_we;
    logic [OCC_W-1:0] hist_waddr;

    assign ra_we      = clr_active_reg || (s1_move && ra_samp);
    assign a_we       = clr_active_reg || (s1_move && a_samp);
    assign hist_waddr = clr_active_reg ? clr_addr_reg : s1_addr_reg;

    srma_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (HIST_DEPTH)
    ) u_ra_hist (
        .clk   (clk),
        .we    (ra_we),
        .waddr (hist_waddr),
        .wdata (clr_active_reg ? '0 : ra_new),
        .re    (accept),
        .raddr (hist_raddr),
        .rdata (ra_rdata)
    );

    srma_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (HIST_DEPTH)
    ) u_a_hist (
        .clk   (clk),
        .we    (a_we),
        .waddr (hist_waddr),
        .wdata (clr_active_reg ? '0 : a_new),
        .re    (accept),
        .raddr (hist_raddr),
        .rdata (a_rdata)
    );

    // output register
    logic [OCC_OUT_W-1:0]   occ_out_reg;
    logic                   ra_out_reg;
    logic                   a_out_reg;
    logic [BIN_COUNT_W-1:0] count_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            occ_out_reg   <= OCC_OUT_W'(s1_occ_reg);
            ra_out_reg    <= ra_samp;
            a_out_reg     <= a_samp;
            count_out_reg <= s1_count;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.occupancy  = occ_out_reg;
    assign rsp.ra_sampled = ra_out_reg;
    assign rsp.a_sampled  = a_out_reg;
    assign rsp.bin_count  = count_out_reg;

    // checks
    a_occ_within_gate: assert property (@(posedge clk) disable iff (!rst_n)
        window_count_reg <= gl)
        else $error("gate occupancy above gate length");

    a_bypass_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        bypass_hit_reg |-> s1_valid_reg)
        else $error("forwarded bin without an item in stage 1");

    a_clear_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!s1_valid_reg && !out_valid_reg))
        else $error("item in flight during histogram clearing");

endmodule

FILE: hw/rtl/srma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word when both ports hit the same entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/srma_tap_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srma_tap_cell
// One bit of a shift line; reports its bit when it sits at the tap.
// ----------------------------------------------------------------------------
module srma_tap_cell import srma_pkg::*; #(
    parameter int INDEX = 0,
    parameter int LEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  line_ctrl_t       ctrl,
    input  logic             din,
    input  logic [LEN_W-1:0] tap_len,
    output logic             dout,
    output logic             tap_hit
);

    logic bit_reg;
    logic bit_next;

    always_comb
    begin
        bit_next = bit_reg;
        if (ctrl.clear)
        begin
            bit_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            bit_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    assign dout    = bit_reg;
    // cell INDEX holds the bit shifted in INDEX+1 ticks ago
    assign tap_hit = bit_reg && (tap_len == LEN_W'(INDEX + 1));

endmodule

FILE: hw/rtl/srma_delay_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srma_delay_line
// Row of shift cells with a movable tap, read before each shift.
// ----------------------------------------------------------------------------
module srma_delay_line import srma_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  line_ctrl_t                 ctrl,
    input  logic                       din,
    input  logic [$clog2(DEPTH+1)-1:0] tap_len,
    output logic                       tap_bit
);

    localparam int LEN_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0] cell_out;
    logic [DEPTH-1:0] cell_hit;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic cell_in;
        if (k == 0)
        begin : g_head
            assign cell_in = din;
        end
        else
        begin : g_body
            assign cell_in = cell_out[k-1];
        end

        srma_tap_cell #(
            .INDEX (k),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .din     (cell_in),
            .tap_len (tap_len),
            .dout    (cell_out[k]),
            .tap_hit (cell_hit[k])
        );
    end

    assign tap_bit = |cell_hit;

endmodule
